/* rtl/core/affc_pkg.sv */
// Shared constants and register codes for the farthest front corner block.
package affc_pkg;

    localparam int NUM_AXES    = 3;
    localparam int NUM_SIDES   = 2;
    localparam int NUM_CORNERS = 8;
    localparam int OUT_WIDTH   = 36;
    localparam int CFG_INDEX_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_EYE_X  = 3'd0,
        REG_EYE_Y  = 3'd1,
        REG_EYE_Z  = 3'd2,
        REG_VIEW_X = 3'd3,
        REG_VIEW_Y = 3'd4,
        REG_VIEW_Z = 3'd5
    } cfg_reg_t;

endpackage

/* rtl/core/affc_front.sv */
// Front stage: eye-relative min/max coordinates and their dot and square products.
module affc_front
    import affc_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                                  clk,
    input  logic                                                  rst_n,
    input  logic                                                  in_valid,
    output logic                                                  in_ready,
    input  logic [NUM_AXES-1:0][COORD_WIDTH-1:0]                  box_lo,
    input  logic [NUM_AXES-1:0][COORD_WIDTH-1:0]                  box_hi,
    input  logic [NUM_AXES-1:0][COORD_WIDTH-1:0]                  eye,
    input  logic [NUM_AXES-1:0][COORD_WIDTH-1:0]                  view,
    output logic                                                  out_valid,
    input  logic                                                  out_ready,
    output logic [NUM_AXES-1:0][NUM_SIDES-1:0][2*COORD_WIDTH:0]   dot_terms,
    output logic [NUM_AXES-1:0][NUM_SIDES-1:0][2*COORD_WIDTH:0]   sq_terms
);

    localparam int DIFF_W = COORD_WIDTH + 1;
    localparam int TERM_W = 2 * COORD_WIDTH + 1;
    localparam int PROD_W = 2 * DIFF_W;

    logic                                          valid_reg;
    logic [NUM_AXES-1:0][NUM_SIDES-1:0][TERM_W-1:0] dot_reg, dot_next;
    logic [NUM_AXES-1:0][NUM_SIDES-1:0][TERM_W-1:0] sq_reg, sq_next;

    always_comb
    begin
        logic signed [DIFF_W-1:0] diff;
        logic signed [COORD_WIDTH-1:0] pt;
        logic signed [TERM_W-1:0] dprod;
        logic signed [PROD_W-1:0] sprod;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            for (int s = 0; s < NUM_SIDES; s++)
            begin
                pt    = (s == 0) ? box_lo[a] : box_hi[a];
                diff  = DIFF_W'(pt) - DIFF_W'($signed(eye[a]));
                dprod = TERM_W'($signed(view[a])) * TERM_W'(diff);
                sprod = PROD_W'(diff) * PROD_W'(diff);
                dot_next[a][s] = dprod;
                // square of a difference never exceeds 2^(2*COORD_WIDTH)
                sq_next[a][s]  = sprod[TERM_W-1:0];
            end
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign dot_terms = dot_reg;
    assign sq_terms  = sq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            dot_reg <= dot_next;
            sq_reg  <= sq_next;
        end
    end

endmodule

/* rtl/core/affc_cell.sv */
// Corner cell: tests one corner against the view plane and folds it into the running max.
module affc_cell
    import affc_pkg::*;
#(
    parameter int COORD_WIDTH = 16,
    parameter int CORNER      = 0
) (
    input  logic                                                  clk,
    input  logic                                                  rst_n,
    input  logic                                                  in_valid,
    output logic                                                  in_ready,
    input  logic [NUM_AXES-1:0][NUM_SIDES-1:0][2*COORD_WIDTH:0]   dot_in,
    input  logic [NUM_AXES-1:0][NUM_SIDES-1:0][2*COORD_WIDTH:0]   sq_in,
    input  logic [2*COORD_WIDTH+2:0]                              best_in,
    output logic                                                  out_valid,
    input  logic                                                  out_ready,
    output logic [NUM_AXES-1:0][NUM_SIDES-1:0][2*COORD_WIDTH:0]   dot_out,
    output logic [NUM_AXES-1:0][NUM_SIDES-1:0][2*COORD_WIDTH:0]   sq_out,
    output logic [2*COORD_WIDTH+2:0]                              best_out
);

    localparam int TERM_W = 2 * COORD_WIDTH + 1;
    localparam int SUM_W  = 2 * COORD_WIDTH + 3;
    localparam logic [NUM_AXES-1:0] SEL = NUM_AXES'(CORNER);

    logic                                           valid_reg;
    logic [NUM_AXES-1:0][NUM_SIDES-1:0][TERM_W-1:0] dot_reg;
    logic [NUM_AXES-1:0][NUM_SIDES-1:0][TERM_W-1:0] sq_reg;
    logic [SUM_W-1:0]                               best_reg, best_next;
    logic signed [SUM_W-1:0]                        dot_sum;
    logic [SUM_W-1:0]                               len_sum;
    logic                                           in_front;

    always_comb
    begin
        dot_sum = '0;
        len_sum = '0;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            dot_sum = dot_sum + SUM_W'($signed(dot_in[a][SEL[a]]));
            len_sum = len_sum + SUM_W'(sq_in[a][SEL[a]]);
        end
        // on the view plane does not count
        in_front  = !dot_sum[SUM_W-1] && (dot_sum != '0);
        best_next = (in_front && (len_sum > best_in)) ? len_sum : best_in;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign dot_out   = dot_reg;
    assign sq_out    = sq_reg;
    assign best_out  = best_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            dot_reg  <= dot_in;
            sq_reg   <= sq_in;
            best_reg <= best_next;
        end
    end

endmodule

/* rtl/core/aabb_farthest_front_corner_top.sv */
// Top level of the farthest front corner block: config registers, front stage, corner chain.
//
// Each box word yields one distance word: the largest exact squared distance from the eye
// to a box corner that lies strictly in front of the eye along the view vector, or zero
// when no corner does; values above 2^36-1 saturate. A box passes from acceptance to the
// output through the front stage, where the six eye-relative
// coordinates are multiplied by the view vector and squared, and then through each of
// eight corner cells, each of which adds its corner's three dot and square terms and
// keeps the larger distance. Every stage holds one box, so a new box is taken every
// cycle; a stalled output fills the chain before s_tready drops. Write the eye and view
// registers only while no box is in flight.
module aabb_farthest_front_corner_top
    import affc_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0]                       cfg_index,
    input  logic [COORD_WIDTH-1:0]                       cfg_data,
    input  logic                                         s_tvalid,
    output logic                                         s_tready,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z, zero pad
    input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]           s_tdata,
    output logic                                         m_tvalid,
    input  logic                                         m_tready,
    // far_dist_sq, zero pad
    output logic [((OUT_WIDTH+7)/8)*8-1:0]               m_tdata
);

    localparam int TERM_W    = 2 * COORD_WIDTH + 1;
    localparam int SUM_W     = 2 * COORD_WIDTH + 3;
    localparam int EXT_W     = (SUM_W > OUT_WIDTH) ? SUM_W : OUT_WIDTH;
    localparam int M_TDATA_W = ((OUT_WIDTH + 7) / 8) * 8;

    // eye point and view vector
    logic [NUM_AXES-1:0][COORD_WIDTH-1:0] eye_reg;
    logic [NUM_AXES-1:0][COORD_WIDTH-1:0] view_reg;

    logic [NUM_AXES-1:0][COORD_WIDTH-1:0] box_lo;
    logic [NUM_AXES-1:0][COORD_WIDTH-1:0] box_hi;

    // stage 0 is the front stage, stage k+1 the output of corner cell k
    logic [NUM_CORNERS:0]                                        stg_valid;
    logic [NUM_CORNERS:0]                                        stg_ready;
    logic [NUM_CORNERS:0][NUM_AXES-1:0][NUM_SIDES-1:0][TERM_W-1:0] stg_dot;
    logic [NUM_CORNERS:0][NUM_AXES-1:0][NUM_SIDES-1:0][TERM_W-1:0] stg_sq;
    logic [NUM_CORNERS:0][SUM_W-1:0]                             stg_best;

    logic [EXT_W-1:0]     best_ext;
    logic [OUT_WIDTH-1:0] far_dist_sq;

    // Configuration writes: decode the index, ignore codes past the list.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eye_reg  <= '0;
            view_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_EYE_X:  eye_reg[0]  <= cfg_data;
                REG_EYE_Y:  eye_reg[1]  <= cfg_data;
                REG_EYE_Z:  eye_reg[2]  <= cfg_data;
                REG_VIEW_X: view_reg[0] <= cfg_data;
                REG_VIEW_Y: view_reg[1] <= cfg_data;
                REG_VIEW_Z: view_reg[2] <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Unpack the box word: min corner in the low fields, max corner above.
    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            box_lo[a] = s_tdata[a*COORD_WIDTH +: COORD_WIDTH];
            box_hi[a] = s_tdata[(a+NUM_AXES)*COORD_WIDTH +: COORD_WIDTH];
        end
    end

    affc_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .box_lo    (box_lo),
        .box_hi    (box_hi),
        .eye       (eye_reg),
        .view      (view_reg),
        .out_valid (stg_valid[0]),
        .out_ready (stg_ready[0]),
        .dot_terms (stg_dot[0]),
        .sq_terms  (stg_sq[0])
    );

    // Start the running max at zero: a box with no front corner reports zero.
    assign stg_best[0] = '0;

    // Eight corner cells; bit a of the cell index picks max on axis a.
    for (genvar k = 0; k < NUM_CORNERS; k++)
    begin : g_cell
        affc_cell #(
            .COORD_WIDTH (COORD_WIDTH),
            .CORNER      (k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stg_valid[k]),
            .in_ready  (stg_ready[k]),
            .dot_in    (stg_dot[k]),
            .sq_in     (stg_sq[k]),
            .best_in   (stg_best[k]),
            .out_valid (stg_valid[k+1]),
            .out_ready (stg_ready[k+1]),
            .dot_out   (stg_dot[k+1]),
            .sq_out    (stg_sq[k+1]),
            .best_out  (stg_best[k+1])
        );
    end

    // The last cell's register is the output register; saturate to the output width.
    assign stg_ready[NUM_CORNERS] = m_tready;
    assign m_tvalid               = stg_valid[NUM_CORNERS];

    assign best_ext    = EXT_W'(stg_best[NUM_CORNERS]);
    assign far_dist_sq = (best_ext > EXT_W'({OUT_WIDTH{1'b1}}))
                       ? {OUT_WIDTH{1'b1}} : best_ext[OUT_WIDTH-1:0];
    assign m_tdata     = M_TDATA_W'(far_dist_sq);

    // Input backpressure only when every stage holds a box and the output is stalled.
    a_full_chain: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready && (&stg_valid)))
        else $error("input stalled while chain has a free stage");

    // A box leaving the front stage into a free first cell lands there next cycle.
    a_front_to_cell: assert property (@(posedge clk) disable iff (!rst_n)
        (stg_valid[0] && stg_ready[0]) |=> stg_valid[1])
        else $error("box lost between front stage and first corner cell");

    // Zero view means zero distance; user must hold registers in flight, not enforced here.
    a_zero_view: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (view_reg == '0)) |-> (far_dist_sq == '0))
        else $error("nonzero distance with zero view vector");

endmodule
